// ----- rtl/core/vcts_pkg.sv -----
// ----------------------------------------------------------------------------
// vcts_pkg
// Shared types, codes and the sequencer program for the value change trace
// store.
// ----------------------------------------------------------------------------
package vcts_pkg;

    localparam int SIG_W       = 4;
    localparam int TIME_W      = 32;
    localparam int VALUE_W     = 32;
    localparam int CFG_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 104;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef logic [2:0] pc_t;

    localparam pc_t PC_IDLE   = 3'd0;
    localparam pc_t PC_CHECK  = 3'd1;
    localparam pc_t PC_COUNT  = 3'd2;
    localparam pc_t PC_SCAN   = 3'd3;
    localparam pc_t PC_RESULT = 3'd4;

    typedef enum logic [2:0] {
        COND_NO_REQ    = 3'd0,
        COND_UNKNOWN   = 3'd1,
        COND_APPEND    = 3'd2,
        COND_SCAN_BUSY = 3'd3,
        COND_OUT_BUSY  = 3'd4
    } cond_t;

    typedef struct packed {
        logic  in_ready;
        logic  check;
        logic  count_load;
        logic  scan;
        logic  out_load;
        cond_t cond;
        pc_t   branch_pc;
        pc_t   next_pc;
    } uword_t;

    // control store: branch_pc when the condition holds, else next_pc
    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t w;
        w = '0;
        unique case (pc)
            PC_IDLE: begin
                w.in_ready  = 1'b1;
                w.cond      = COND_NO_REQ;
                w.branch_pc = PC_IDLE;
                w.next_pc   = PC_CHECK;
            end
            PC_CHECK: begin
                w.check     = 1'b1;
                w.cond      = COND_UNKNOWN;
                w.branch_pc = PC_RESULT;
                w.next_pc   = PC_COUNT;
            end
            PC_COUNT: begin
                w.count_load = 1'b1;
                w.cond       = COND_APPEND;
                w.branch_pc  = PC_RESULT;
                w.next_pc    = PC_SCAN;
            end
            PC_SCAN: begin
                w.scan      = 1'b1;
                w.cond      = COND_SCAN_BUSY;
                w.branch_pc = PC_SCAN;
                w.next_pc   = PC_RESULT;
            end
            PC_RESULT: begin
                w.out_load  = 1'b1;
                w.cond      = COND_OUT_BUSY;
                w.branch_pc = PC_RESULT;
                w.next_pc   = PC_IDLE;
            end
            default: begin
                w.cond      = COND_NO_REQ;
                w.branch_pc = PC_IDLE;
                w.next_pc   = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/vcts_ram.sv -----
// ----------------------------------------------------------------------------
// vcts_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module vcts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/value_change_trace_store.sv -----
// ----------------------------------------------------------------------------
// value_change_trace_store
// Per-signal lists of value changes with append and point-in-time query.
// ----------------------------------------------------------------------------
// One request is handled at a time by a small microcoded sequencer. An append
// passes through the check, count and result steps; a query also scans, between
// the count and result steps, the changes stored for that signal (at most
// CHANGES_PER_SIGNAL), reading the list through the single read port of the
// trace RAM at one entry per cycle. An unknown signal goes from the check step
// straight to the result. The result sits in an output register, so the next
// request is taken while it waits. No clearing pass follows reset: the
// per-signal counts carry valid bits that reset clears at once.
module value_change_trace_store
    import vcts_pkg::*;
#(
    parameter int SIGNAL_SLOTS       = 16,
    parameter int CHANGES_PER_SIGNAL = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration: signals_declared
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    // requests
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // signal_index, event_time, new_value
    input  logic                 s_tuser,   // action
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, value_then, previous_change_time, next_change_time, next_exists
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int SLOT_AW  = (SIGNAL_SLOTS > 1) ? $clog2(SIGNAL_SLOTS) : 1;
    localparam int DEPTH    = SIGNAL_SLOTS * CHANGES_PER_SIGNAL;
    localparam int TRACE_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(CHANGES_PER_SIGNAL + 1);
    localparam int ENTRY_W  = TIME_W + VALUE_W;
    localparam int PAD_W    = M_TDATA_W - (STATUS_W + VALUE_W + 2 * TIME_W + 1);

    // sequencer
    pc_t    pc_reg, pc_next;
    uword_t uw;
    logic   branch;

    // request fields
    logic               action_reg;
    logic [SIG_W-1:0]   sig_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [CFG_W-1:0]   declared_reg;

    // datapath
    logic [TRACE_AW-1:0] base_reg;
    logic [CNT_W-1:0]    count_reg, idx_reg;
    logic                pend_reg;
    logic [SIGNAL_SLOTS-1:0] cnt_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [VALUE_W-1:0]  val_reg;
    logic [TIME_W-1:0]   prev_reg, nxt_reg;
    logic                has_next_reg, val_done_reg, prev_done_reg;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic                in_acc, unknown, full, issue, scan_busy, out_free, do_append;
    logic [SLOT_AW-1:0]  slot;
    logic [CNT_W-1:0]    cnt_rd_data, count_now;
    logic [ENTRY_W-1:0]  trace_rd_data;
    logic [TIME_W-1:0]   ct;
    logic [VALUE_W-1:0]  cv;

    assign uw       = ucode_rom(pc_reg);
    assign s_tready = uw.in_ready;
    assign in_acc   = s_tvalid && uw.in_ready;

    assign slot    = SLOT_AW'(sig_reg);
    assign unknown = ({1'b0, sig_reg} >= declared_reg)
                     || (32'(sig_reg) >= 32'(SIGNAL_SLOTS));

    assign count_now = cnt_valid_reg[slot] ? cnt_rd_data : '0;
    assign full      = (count_now == CNT_W'(CHANGES_PER_SIGNAL));
    assign do_append = uw.count_load && (action_reg == ACT_APPEND) && !full;

    assign issue     = uw.scan && (idx_reg != count_reg);
    assign scan_busy = issue || pend_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign ct = trace_rd_data[TIME_W-1:0];
    assign cv = trace_rd_data[ENTRY_W-1:TIME_W];

    always_comb begin
        unique case (uw.cond)
            COND_NO_REQ:    branch = !in_acc;
            COND_UNKNOWN:   branch = unknown;
            COND_APPEND:    branch = (action_reg == ACT_APPEND);
            COND_SCAN_BUSY: branch = scan_busy;
            COND_OUT_BUSY:  branch = !out_free;
            default:        branch = 1'b0;
        endcase
        pc_next = branch ? uw.branch_pc : uw.next_pc;
    end

    vcts_ram #(
        .WIDTH (CNT_W),
        .DEPTH (SIGNAL_SLOTS)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (do_append),
        .wr_addr (slot),
        .wr_data (count_now + CNT_W'(1)),
        .rd_en   (uw.check),
        .rd_addr (slot),
        .rd_data (cnt_rd_data)
    );

    vcts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_trace_ram (
        .aclk    (aclk),
        .wr_en   (do_append),
        .wr_addr (base_reg + TRACE_AW'(count_now)),
        .wr_data ({value_reg, time_reg}),
        .rd_en   (issue),
        .rd_addr (base_reg + TRACE_AW'(idx_reg)),
        .rd_data (trace_rd_data)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= PC_IDLE;
            declared_reg  <= '0;
            cnt_valid_reg <= '0;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            pend_reg <= issue;
            if (cfg_wr_en) begin
                declared_reg <= cfg_wr_data;
            end
            if (do_append) begin
                cnt_valid_reg[slot] <= 1'b1;
            end
            if (uw.out_load && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            action_reg <= s_tuser;
            sig_reg    <= s_tdata[SIG_W-1:0];
            time_reg   <= s_tdata[SIG_W+TIME_W-1:SIG_W];
            value_reg  <= s_tdata[SIG_W+TIME_W+VALUE_W-1:SIG_W+TIME_W];
        end
        if (uw.check) begin
            base_reg      <= TRACE_AW'(32'(sig_reg) * 32'(CHANGES_PER_SIGNAL));
            status_reg    <= unknown ? ST_UNKNOWN : ST_OK;
            val_reg       <= '0;
            prev_reg      <= '0;
            nxt_reg       <= '0;
            has_next_reg  <= 1'b0;
            val_done_reg  <= 1'b0;
            prev_done_reg <= 1'b0;
        end
        if (uw.count_load) begin
            count_reg <= count_now;
            idx_reg   <= '0;
            if (action_reg == ACT_APPEND && full) begin
                status_reg <= ST_FULL;
            end
        end
        if (issue) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        // evaluate the entry read in the previous cycle
        if (pend_reg) begin
            if (!val_done_reg) begin
                if (ct > time_reg) begin
                    val_done_reg <= 1'b1;
                end else begin
                    val_reg <= cv;
                    if (ct == time_reg) begin
                        val_done_reg <= 1'b1;
                    end
                end
            end
            if (!prev_done_reg) begin
                if (ct >= time_reg) begin
                    prev_done_reg <= 1'b1;
                end else begin
                    prev_reg <= ct;
                end
            end
            if (!has_next_reg && ct > time_reg) begin
                nxt_reg      <= ct;
                has_next_reg <= 1'b1;
            end
        end
        if (uw.out_load && out_free) begin
            m_data_reg <= {{PAD_W{1'b0}}, has_next_reg, nxt_reg, prev_reg, val_reg,
                           status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule
